/* rtl/bs_pkg.sv */
// bitonic sorter package: sizes, bank mapping, sequencer struct and state codes
// depends on nothing; imported by bs_seq and bitonic_sorter_unit
`default_nettype none

package bs_pkg;

  // batch and network sizes
  localparam int BatchSize = 16;
  localparam int LogP      = (BatchSize > 1) ? $clog2(BatchSize) : 1;
  localparam int NetSize   = 1 << LogP;
  localparam int IdxW      = LogP;
  localparam int CntW      = $clog2(BatchSize + 1);
  localparam int KLogW     = $clog2(LogP + 1);

  // two banks, split by index parity so compare partners never share a bank
  localparam int BankDepth = NetSize / 2;
  localparam int BankAw    = (LogP > 1) ? LogP - 1 : 1;

  // stored entry: pad flag above the 32-bit value
  localparam int ValW   = 32;
  localparam int EntryW = ValW + 1;
  localparam int KeyW   = ValW + 2;

  // register map
  localparam int ApbAw      = 3;
  localparam int ApbDw      = 32;
  localparam int RegSortDir = 0;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_CAP,
    ST_HOLD
  } bs_state_t;

  typedef struct packed {
    logic            busy;
    logic            issue;
    logic            first;
    logic            blk;
    logic [IdxW-1:0] x;
    logic [IdxW-1:0] y;
  } seq_op_t;

  function automatic logic bank_of(input logic [IdxW-1:0] idx);
    return ^idx;
  endfunction

  function automatic logic [BankAw-1:0] bank_addr(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] s;
    s = idx >> 1;
    return BankAw'(s);
  endfunction

endpackage

`default_nettype wire

/* rtl/bs_ram.sv */
// generic simple dual-port ram: one write port, one registered read port
// depends on nothing
`default_nettype none

module bs_ram #(
  parameter int Width = 33,
  parameter int Depth = 8
) (
  input  wire                                      clk,
  input  wire                                      we,
  input  wire  [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  wire  [Width-1:0]                         wdata,
  input  wire  [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/bs_seq.sv */
// bitonic network sequencer: walks stages and compare-exchange pairs
// depends on bs_pkg
`default_nettype none

module bs_seq
  import bs_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     start,
  output seq_op_t op_out
);

  localparam logic [BankAw-1:0] OpLast  = BankAw'(NetSize / 2 - 1);
  localparam int                BlkSelW = (IdxW > 1) ? $clog2(IdxW) : 1;

  logic [KLogW-1:0]  k_log;
  logic [KLogW-1:0]  j_log;
  logic [BankAw-1:0] op;
  logic              busy;
  logic              gap;

  logic [IdxW-1:0] opx;
  logic [IdxW-1:0] mask;
  logic [IdxW-1:0] xi;
  logic [IdxW-1:0] sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      gap   <= 1'b0;
      k_log <= '0;
      j_log <= '0;
      op    <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      gap   <= 1'b0;
      k_log <= KLogW'(1);
      j_log <= '0;
      op    <= '0;
    end else if (busy) begin
      if (gap) begin
        gap <= 1'b0;
      end else if (op == OpLast) begin
        // end of a stage: one idle slot so the last write lands first
        op  <= '0;
        gap <= 1'b1;
        if (j_log == '0) begin
          if (k_log == KLogW'(LogP)) begin
            busy <= 1'b0;
          end else begin
            k_log <= k_log + KLogW'(1);
            j_log <= k_log;
          end
        end else begin
          j_log <= j_log - KLogW'(1);
        end
      end else begin
        op <= op + BankAw'(1);
      end
    end
  end

  // insert a zero at bit j of the pair number to get the lower index
  always_comb begin
    opx  = IdxW'(op);
    sh   = IdxW'(1) << j_log;
    mask = sh - IdxW'(1);
    xi   = ((opx & ~mask) << 1) | (opx & mask);
    op_out.busy  = busy;
    op_out.issue = busy && !gap;
    op_out.first = (k_log == KLogW'(1));
    op_out.x     = xi;
    op_out.y     = xi | sh;
    op_out.blk   = (k_log >= KLogW'(LogP)) ? 1'b0 : xi[k_log[BlkSelW-1:0]];
  end

endmodule

`default_nettype wire

/* rtl/bitonic_sorter_unit.sv */
// bitonic sorter top level: load, in-place banked sort, ordered emit
// depends on bs_pkg, bs_ram and bs_seq
`default_nettype none

// Collects a batch of up to BatchSize signed 32-bit values, one per request,
// and closes it on in_last or when the store is full. The values sit in two
// one-read one-write memory banks split by index parity, so both members of
// each compare-exchange pair are read in one cycle and written back in the
// next. Loading accepts a new value whenever one is offered. The sort runs
// LogP*(LogP+1)/2 stages of NetSize/2 pair operations, one pair issued per
// cycle with an idle gap after each stage so that the next stage reads settled
// data; with BatchSize 16 there are 10 stages, and the first result is then read.
// Slots beyond the batch are marked as pads on the first stage's read and
// always sort to the end. Results then leave one at a time, each read from
// a bank and registered before it is offered, with the last one flagged; no
// new request is taken until the batch is fully out.
// sort_direction (1 ascending, 0 descending, reset 1) is sampled when a batch
// closes, and may only be written while the block is idle.
module bitonic_sorter_unit
  import bs_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  // request channel
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire  signed [ValW-1:0] in_value,
  input  wire                    in_last,
  // result channel
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic signed [ValW-1:0] out_value,
  output logic                   out_last,
  // configuration port
  input  wire                    psel,
  input  wire                    penable,
  input  wire                    pwrite,
  input  wire  [ApbAw-1:0]       paddr,
  input  wire  [ApbDw-1:0]       pwdata,
  output logic [ApbDw-1:0]       prdata,
  output logic                   pready
);

  localparam logic signed [KeyW-1:0] KeyMax = KeyW'(64'sd1 <<< ValW);
  localparam logic signed [KeyW-1:0] KeyMin = -KeyMax;

  bs_state_t state, state_next;

  logic              sort_direction;
  logic              up;             // direction latched at batch close
  logic [CntW-1:0]   loaded_count;
  logic [IdxW-1:0]   emit_idx;

  // pair in flight between read and write back
  logic              pv;
  logic [IdxW-1:0]   p_x;
  logic [IdxW-1:0]   p_y;
  logic              p_dir;
  logic              p_first;

  seq_op_t           seq_op;
  logic              seq_start;

  // bank ports
  logic              we     [2];
  logic [BankAw-1:0] waddr  [2];
  logic [EntryW-1:0] wdata  [2];
  logic [BankAw-1:0] raddr  [2];
  logic [EntryW-1:0] rdata  [2];

  logic              in_fire;
  logic              out_fire;
  logic              close;
  logic              cfg_wr;
  logic [IdxW-1:0]   load_idx;
  logic [IdxW-1:0]   rd_emit;
  logic [EntryW-1:0] ex;
  logic [EntryW-1:0] ey;
  logic [EntryW-1:0] nx;
  logic [EntryW-1:0] ny;
  logic              swap;
  logic              emit_last;

  function automatic logic signed [KeyW-1:0] key_of(input logic [EntryW-1:0] e,
                                                     input logic dir_up);
    logic signed [KeyW-1:0] k;
    if (e[ValW]) begin
      k = dir_up ? KeyMax : KeyMin;
    end else begin
      k = KeyW'(signed'(e[ValW-1:0]));
    end
    return k;
  endfunction

  // configuration port, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_direction <= 1'b1;
    end else if (cfg_wr && (paddr[ApbAw-1:2] == (ApbAw-2)'(RegSortDir))) begin
      sort_direction <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ApbAw-1:2] == (ApbAw-2)'(RegSortDir)) begin
      prdata = ApbDw'(sort_direction);
    end
  end

  // handshakes
  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_HOLD);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign load_idx  = loaded_count[IdxW-1:0];
  assign close     = in_fire && (in_last || (loaded_count == CntW'(BatchSize - 1)));
  assign seq_start = close;
  assign emit_last = ((CntW'(emit_idx) + CntW'(1)) == loaded_count);

  bs_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (seq_start),
    .op_out (seq_op)
  );

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (close) begin
          state_next = ST_SORT;
        end
      end
      ST_SORT: begin
        // network drained: first result read goes out this cycle
        if (!seq_op.busy && !pv) begin
          state_next = ST_CAP;
        end
      end
      ST_CAP: begin
        state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_fire) begin
          state_next = out_last ? ST_LOAD : ST_CAP;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // batch count and direction latch
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      up           <= 1'b1;
    end else begin
      if (in_fire) begin
        loaded_count <= loaded_count + CntW'(1);
      end else if (out_fire && out_last) begin
        loaded_count <= '0;
      end
      if (close) begin
        up <= sort_direction;
      end
    end
  end

  // emit index
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
    end else if (state == ST_SORT) begin
      emit_idx <= '0;
    end else if (out_fire) begin
      emit_idx <= emit_idx + IdxW'(1);
    end
  end

  assign rd_emit = (state == ST_SORT) ? '0 : (emit_idx + IdxW'(1));

  // pair pipeline register
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= (state == ST_SORT) && seq_op.issue;
    end
  end

  always_ff @(posedge clk) begin
    p_x     <= seq_op.x;
    p_y     <= seq_op.y;
    p_first <= seq_op.first;
    p_dir   <= (seq_op.blk == 1'b0) == up;
  end

  // compare-exchange on returned data; pads substituted on the first stage
  always_comb begin
    ex = rdata[bank_of(p_x)];
    ey = rdata[!bank_of(p_x)];
    if (p_first && (CntW'(p_x) >= loaded_count)) begin
      ex = {1'b1, {ValW{1'b0}}};
    end
    if (p_first && (CntW'(p_y) >= loaded_count)) begin
      ey = {1'b1, {ValW{1'b0}}};
    end
    if (p_dir) begin
      swap = key_of(ex, up) > key_of(ey, up);
    end else begin
      swap = key_of(ex, up) < key_of(ey, up);
    end
    nx = swap ? ey : ex;
    ny = swap ? ex : ey;
  end

  // bank port steering; once the network stops, the reads fetch results
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      we[b]    = 1'b0;
      waddr[b] = bank_addr(load_idx);
      wdata[b] = {1'b0, in_value};
      if ((state == ST_SORT) && seq_op.busy) begin
        raddr[b] = (bank_of(seq_op.x) == 1'(b)) ? bank_addr(seq_op.x)
                                                : bank_addr(seq_op.y);
      end else begin
        raddr[b] = bank_addr(rd_emit);
      end
      if (in_fire && (bank_of(load_idx) == 1'(b))) begin
        we[b] = 1'b1;
      end
      if (pv) begin
        we[b] = 1'b1;
        if (bank_of(p_x) == 1'(b)) begin
          waddr[b] = bank_addr(p_x);
          wdata[b] = nx;
        end else begin
          waddr[b] = bank_addr(p_y);
          wdata[b] = ny;
        end
      end
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_bank
    bs_ram #(
      .Width (EntryW),
      .Depth (BankDepth)
    ) u_bank (
      .clk   (clk),
      .we    (we[g]),
      .waddr (waddr[g]),
      .wdata (wdata[g]),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_CAP) begin
      out_value <= signed'(rdata[bank_of(emit_idx)][ValW-1:0]);
      out_last  <= emit_last;
    end
  end

  // a closed batch always holds at least one value and never more than the store
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> ((loaded_count != '0) &&
                            (loaded_count <= CntW'(BatchSize))))
    else $error("batch count out of range outside load");

  // filling the last entry closes the batch even without in_last
  a_full_close: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (loaded_count == CntW'(BatchSize - 1))) |=> (state == ST_SORT))
    else $error("full store did not close the batch");

  // the network only runs while sorting
  a_seq_in_sort: assert property (@(posedge clk) disable iff (rst)
    (seq_op.busy || pv) |-> (state == ST_SORT))
    else $error("network active outside sort");

  // the last result hands the block back to loading with an empty store
  a_last_return: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_last) |=> (in_ready && (loaded_count == '0)))
    else $error("block not ready after last result");

endmodule

`default_nettype wire
